/* sv/fpfa_pkg.sv */
// Shared types and codes of the fixed partition fit allocator.
// Used by every module of the block; depends on nothing.
package fpfa_pkg;

   localparam int DEF_NUM_PARTITIONS = 128;
   localparam int DEF_SIZE_BITS      = 16;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_ALLOC = 2'd1;
   localparam logic [1:0] ACT_FREE  = 2'd2;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic REG_FIT_MODE   = 1'b0;
   localparam logic REG_PART_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [6:0]  partition_index;
      logic [15:0] size_value;
   } req_word_type;

   typedef struct packed {
      logic       granted;
      logic [6:0] chosen_partition;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0] fit_mode;
      logic [7:0] partition_count;
   } cfg_type;

   typedef struct packed {
      logic rd_en;
      logic size_we;
      logic taken_we;
      logic taken_wdata;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

endpackage

/* sv/fixed_partition_fit_allocator.sv */
// Top level of the fixed partition fit allocator: configuration registers,
// sequencer and partition table memories. Depends on fpfa_pkg and all fpfa_ modules.
//
// A load word is written to the tables as it is accepted. A free-all word is
// accepted, then one taken flag is cleared per cycle. An allocate word with a
// saturated partition count n scans the table: the scan reads one entry per
// cycle through the single read port of the size and taken memories, then the
// drain state empties the read pipeline and the finish state, once the result
// register is free, marks the winner and loads the result register (with n zero
// the scan and drain are skipped). A result waiting in the result register does
// not hold back the next load or free-all word. After reset every taken flag is
// cleared before the first word is accepted; configuration writes are taken throughout.
module fixed_partition_fit_allocator #(
   parameter int NUM_PARTITIONS = fpfa_pkg::DEF_NUM_PARTITIONS,
   parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fpfa_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fpfa_pkg::rsp_word_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import fpfa_pkg::*;

   localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

   cfg_type              cfg;
   mem_ctl_type          mem_ctl;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     size_waddr;
   logic [SIZE_BITS-1:0] size_wdata;
   logic [IDX_W-1:0]     taken_waddr;
   logic [SIZE_BITS-1:0] size_rdata;
   logic                 taken_rdata;

   fpfa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fpfa_ctrl #(
      .NUM_PARTITIONS (NUM_PARTITIONS),
      .SIZE_BITS      (SIZE_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mem_ctl     (mem_ctl),
      .rd_addr     (rd_addr),
      .size_waddr  (size_waddr),
      .size_wdata  (size_wdata),
      .taken_waddr (taken_waddr),
      .size_rdata  (size_rdata),
      .taken_rdata (taken_rdata)
   );

   fpfa_table #(
      .NUM_PARTITIONS (NUM_PARTITIONS),
      .SIZE_BITS      (SIZE_BITS)
   ) u_table (
      .clock       (clock),
      .mem_ctl     (mem_ctl),
      .rd_addr     (rd_addr),
      .size_waddr  (size_waddr),
      .size_wdata  (size_wdata),
      .taken_waddr (taken_waddr),
      .size_rdata  (size_rdata),
      .taken_rdata (taken_rdata)
   );

endmodule

/* sv/fpfa_csr.sv */
// Configuration registers (fit mode, partition count) behind an APB-style port.
// Depends on fpfa_pkg.
module fpfa_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output fpfa_pkg::cfg_type  cfg
);
   import fpfa_pkg::*;

   logic [1:0] fit_mode_ff, fit_mode_in;
   logic [7:0] count_ff, count_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      fit_mode_in = fit_mode_ff;
      count_in    = count_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_FIT_MODE:   fit_mode_in = pwdata[1:0];
            REG_PART_COUNT: count_in    = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FIT_MODE:   prdata = {30'b0, fit_mode_ff};
         REG_PART_COUNT: prdata = {24'b0, count_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= FIT_FIRST;
         count_ff    <= '0;
      end else begin
         fit_mode_ff <= fit_mode_in;
         count_ff    <= count_in;
      end
   end

   assign cfg.fit_mode        = fit_mode_ff;
   assign cfg.partition_count = count_ff;

endmodule

/* sv/fpfa_table.sv */
// Partition size memory and taken-flag memory, one write and one registered
// read port each. Depends on fpfa_pkg.
module fpfa_table #(
   parameter int NUM_PARTITIONS = fpfa_pkg::DEF_NUM_PARTITIONS,
   parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS,
   localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1
) (
   input  logic                  clock,
   input  fpfa_pkg::mem_ctl_type mem_ctl,
   input  logic [IDX_W-1:0]      rd_addr,
   input  logic [IDX_W-1:0]      size_waddr,
   input  logic [SIZE_BITS-1:0]  size_wdata,
   input  logic [IDX_W-1:0]      taken_waddr,
   output logic [SIZE_BITS-1:0]  size_rdata,
   output logic                  taken_rdata
);
   import fpfa_pkg::*;

   logic [SIZE_BITS-1:0] size_mem [NUM_PARTITIONS];
   logic                 taken_mem [NUM_PARTITIONS];

   always_ff @(posedge clock) begin
      if (mem_ctl.size_we) begin
         size_mem[size_waddr] <= size_wdata;
      end
      if (mem_ctl.rd_en) begin
         size_rdata <= size_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.taken_we) begin
         taken_mem[taken_waddr] <= mem_ctl.taken_wdata;
      end
      if (mem_ctl.rd_en) begin
         taken_rdata <= taken_mem[rd_addr];
      end
   end

endmodule

/* sv/fpfa_ctrl.sv */
// Sequencer: load, free-all sweep, allocate scan with fit selection, result
// register. Depends on fpfa_pkg; drives the ports of fpfa_table.
module fpfa_ctrl #(
   parameter int NUM_PARTITIONS = fpfa_pkg::DEF_NUM_PARTITIONS,
   parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS,
   localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1,
   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fpfa_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fpfa_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fpfa_pkg::rsp_word_type rsp_data,
   output fpfa_pkg::mem_ctl_type  mem_ctl,
   output logic [IDX_W-1:0]       rd_addr,
   output logic [IDX_W-1:0]       size_waddr,
   output logic [SIZE_BITS-1:0]   size_wdata,
   output logic [IDX_W-1:0]       taken_waddr,
   input  logic [SIZE_BITS-1:0]   size_rdata,
   input  logic                   taken_rdata
);
   import fpfa_pkg::*;

   ctrl_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [SIZE_BITS-1:0] req_size_ff, req_size_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_ff, rsp_in;

   logic [CNT_W-1:0]     sat_count;
   logic                 slot_free;
   logic                 scan_last;
   logic                 clr_last;
   logic                 load_in_range;
   logic                 cand;

   assign sat_count = (int'(cfg.partition_count) > NUM_PARTITIONS) ?
                      CNT_W'(NUM_PARTITIONS) : CNT_W'(cfg.partition_count);
   assign slot_free     = !rsp_valid_ff || rsp_ready;
   assign scan_last     = (CNT_W'(scan_ff) + CNT_W'(1)) == n_ff;
   assign clr_last      = clr_ff == IDX_W'(NUM_PARTITIONS - 1);
   assign load_in_range = int'(req_data.partition_index) < NUM_PARTITIONS;
   assign cand          = !taken_rdata && (size_rdata >= req_size_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action == ACT_ALLOC) begin
                  state_in = (sat_count == '0) ? ST_FINISH : ST_SCAN;
               end else if (req_data.action == ACT_FREE) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready           = 1'b0;
      mem_ctl             = '0;
      rd_addr             = scan_ff;
      size_waddr          = IDX_W'(req_data.partition_index);
      size_wdata          = SIZE_BITS'(req_data.size_value);
      taken_waddr         = IDX_W'(req_data.partition_index);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_data.action == ACT_LOAD && load_in_range) begin
               mem_ctl.size_we  = 1'b1;
               mem_ctl.taken_we = 1'b1;
            end
         end
         ST_CLEAR: begin
            mem_ctl.taken_we = 1'b1;
            taken_waddr      = clr_ff;
         end
         ST_SCAN: mem_ctl.rd_en = 1'b1;
         ST_FINISH: begin
            mem_ctl.taken_we    = slot_free && found_ff;
            mem_ctl.taken_wdata = 1'b1;
            taken_waddr         = pick_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      eval_idx_in  = scan_ff;
      eval_vld_in  = 1'b0;
      n_in         = n_ff;
      req_size_in  = req_size_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.action == ACT_ALLOC) begin
               scan_in     = '0;
               n_in        = sat_count;
               req_size_in = SIZE_BITS'(req_data.size_value);
               found_in    = 1'b0;
               pick_in     = '0;
            end else if (req_valid && req_data.action == ACT_FREE) begin
               clr_in = '0;
            end
         end
         ST_CLEAR: clr_in = clr_ff + IDX_W'(1);
         ST_SCAN: begin
            eval_vld_in = 1'b1;
            scan_in     = scan_ff + IDX_W'(1);
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.granted          = found_ff;
               rsp_in.chosen_partition = found_ff ? 7'(pick_ff) : 7'd0;
            end
         end
         default: ;
      endcase
      if (eval_vld_ff && cand) begin
         if (!found_ff) begin
            found_in = 1'b1;
            pick_in  = eval_idx_ff;
            best_in  = size_rdata;
         end else begin
            case (cfg.fit_mode)
               FIT_BEST: begin
                  if (size_rdata <= best_ff) begin
                     pick_in = eval_idx_ff;
                     best_in = size_rdata;
                  end
               end
               FIT_WORST: begin
                  if (size_rdata >= best_ff) begin
                     pick_in = eval_idx_ff;
                     best_in = size_rdata;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         eval_vld_ff  <= 1'b0;
         n_ff         <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         eval_vld_ff  <= eval_vld_in;
         n_ff         <= n_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= eval_idx_in;
      req_size_ff <= req_size_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
